### hw/rtl/aabb_pkg.sv
package aabb_pkg;

	localparam int SLOT_W  = 3;
	localparam int KIND_W  = 5;
	localparam int COORD_W = 16;
	localparam int DIM_W   = 15;
	localparam int MASK_W  = 32;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_ERASE = 2'd1,
		OP_SCAN  = 2'd2,
		OP_LOAD  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_EMPTY = 3'd2,
		ST_HIT   = 3'd3,
		ST_DONE  = 3'd4
	} status_t;

	// which result the datapath forms on an emit command
	typedef enum logic [2:0] {
		EM_ADD   = 3'd0,
		EM_ERASE = 3'd1,
		EM_LOAD  = 3'd2,
		EM_HIT_A = 3'd3,
		EM_HIT_B = 3'd4,
		EM_DONE  = 3'd5
	} emit_sel_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [DIM_W-1:0]          w;
		logic [DIM_W-1:0]          h;
		logic [KIND_W-1:0]         kind;
		logic                      listens;
	} box_t;

	typedef struct packed {
		logic              idle;
		logic              pair_rd;
		logic              mask_rd;
		logic              emit;
		emit_sel_t         sel;
		logic [SLOT_W-1:0] slot_a;
		logic [SLOT_W-1:0] slot_b;
	} dp_cmd_t;

	typedef struct packed {
		logic in_valid;
		op_t  op;
		logic out_free;
		logic pair_used;
		logic hit_a;
		logic hit_b;
	} dp_stat_t;

endpackage

### hw/rtl/aabb_if.sv
interface aabb_in_if import aabb_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic signed [COORD_W-1:0] box_x;
	logic signed [COORD_W-1:0] box_y;
	logic [DIM_W-1:0]          box_w;
	logic [DIM_W-1:0]          box_h;
	logic [KIND_W-1:0]         kind;
	logic                      has_listener;
	logic [SLOT_W-1:0]         slot;
	logic [MASK_W-1:0]         mask_row;

	modport source (output valid, op, box_x, box_y, box_w, box_h, kind, has_listener, slot,
		mask_row, input ready);
	modport sink (input valid, op, box_x, box_y, box_w, box_h, kind, has_listener, slot,
		mask_row, output ready);
endinterface

interface aabb_out_if import aabb_pkg::*;;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [SLOT_W-1:0] receiver_slot;
	logic [SLOT_W-1:0] other_slot;
	logic              last;

	modport source (output valid, status, receiver_slot, other_slot, last, input ready);
	modport sink (input valid, status, receiver_slot, other_slot, last, output ready);
endinterface

### hw/rtl/aabb_pair_collision_table.sv
// Channel  Modport  Beat carries
// item     sink     op, box_x, box_y, box_w, box_h, kind, has_listener, slot, mask_row
// result   source   status, receiver_slot, other_slot, last
//
// Add, erase and load: the beat is latched, then the result is registered in the execute state
// once the output register is free; the next beat is taken back in idle.
// Scan: a pair with a free slot is skipped; a pair in use goes through a box table read, an
// overlap test with mask table read and two hit slots; the walk ends with a done result.
// Reset clears slot occupancy and mask row valid bits at once; no clearing pass.
// A stalled result holds the walk; the next item is taken once the last result is queued.
module aabb_pair_collision_table import aabb_pkg::*; #(
	parameter int SLOTS = 8,
	parameter int KINDS = 32
) (
	input logic        clk,
	input logic        arst_n,
	aabb_in_if.sink    item,
	aabb_out_if.source result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	aabb_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	aabb_dp #(
		.SLOTS(SLOTS),
		.KINDS(KINDS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule

### hw/rtl/aabb_ctrl.sv
module aabb_ctrl import aabb_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam int IW = $clog2(SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PAIR,
		S_OVL,
		S_HITA,
		S_HITB,
		S_DONE
	} state_t;

	state_t        state_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] k_q;
	logic          last_k;
	logic          last_i;
	logic [IW-1:0] i_next;

	assign last_k = (k_q == IW'(SLOTS - 1));
	assign last_i = (i_q == IW'(SLOTS - 2));
	assign i_next = i_q + 1'b1;

	always_comb begin
		cmd         = '0;
		cmd.sel     = EM_DONE;
		cmd.slot_a  = SLOT_W'(i_q);
		cmd.slot_b  = SLOT_W'(k_q);
		unique case (state_q)
			S_IDLE: cmd.idle = 1'b1;
			S_EXEC: begin
				cmd.emit = (stat.op != OP_SCAN) && stat.out_free;
				unique case (stat.op)
					OP_ADD:   cmd.sel = EM_ADD;
					OP_ERASE: cmd.sel = EM_ERASE;
					OP_LOAD:  cmd.sel = EM_LOAD;
					default:  cmd.sel = EM_DONE;
				endcase
			end
			S_PAIR: cmd.pair_rd = stat.pair_used;
			S_OVL:  cmd.mask_rd = 1'b1;
			S_HITA: begin
				cmd.sel  = EM_HIT_A;
				cmd.emit = stat.hit_a && stat.out_free;
			end
			S_HITB: begin
				cmd.sel  = EM_HIT_B;
				cmd.emit = stat.hit_b && stat.out_free;
			end
			S_DONE: begin
				cmd.sel  = EM_DONE;
				cmd.emit = stat.out_free;
			end
			default: cmd.idle = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (stat.in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (stat.op == OP_SCAN) begin
						i_q     <= '0;
						k_q     <= IW'(1);
						state_q <= S_PAIR;
					end else if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_PAIR: begin
					if (stat.pair_used) begin
						state_q <= S_OVL;
					end else if (last_k) begin
						if (last_i) begin
							state_q <= S_DONE;
						end else begin
							i_q <= i_next;
							k_q <= i_next + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_OVL: state_q <= S_HITA;
				S_HITA: begin
					if (!stat.hit_a || stat.out_free) state_q <= S_HITB;
				end
				S_HITB: begin
					if (!stat.hit_b || stat.out_free) begin
						if (last_k) begin
							if (last_i) begin
								state_q <= S_DONE;
							end else begin
								i_q     <= i_next;
								k_q     <= i_next + 1'b1;
								state_q <= S_PAIR;
							end
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_PAIR;
						end
					end
				end
				S_DONE: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/aabb_dp.sv
module aabb_dp import aabb_pkg::*; #(
	parameter int SLOTS = 8,
	parameter int KINDS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	aabb_in_if.sink    item,
	aabb_out_if.source result,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat
);

	localparam int IW = $clog2(SLOTS);
	localparam int KW = $clog2(KINDS);

	// latched input beat
	op_t               op_q;
	box_t              box_q;
	logic [SLOT_W-1:0] slot_q;
	logic [MASK_W-1:0] mask_row_q;

	logic [SLOTS-1:0]  used_q;
	box_t              box_mem [SLOTS];
	logic [MASK_W-1:0] mask_mem [KINDS];
	logic [KINDS-1:0]  mask_vld_q;

	// pair pipeline
	box_t              box_a_s1;
	box_t              box_b_s1;
	logic              ovl_s2;
	logic              listen_a_s2;
	logic              listen_b_s2;
	logic              kin_a_s2;
	logic              kin_b_s2;
	logic [KIND_W-1:0] kind_a_s2;
	logic [KIND_W-1:0] kind_b_s2;
	logic [MASK_W-1:0] mask_a_s2;
	logic [MASK_W-1:0] mask_b_s2;

	// output register
	logic              out_valid_q;
	status_t           out_st_q;
	logic [SLOT_W-1:0] out_rcv_q;
	logic [SLOT_W-1:0] out_oth_q;
	logic              out_last_q;

	logic              in_fire;
	logic              out_free;
	logic              free_found;
	logic [IW-1:0]     free_idx;
	logic              erase_ok;
	logic              row_ok;
	logic              kin_a;
	logic              kin_b;
	logic              ovl;
	logic signed [COORD_W+1:0] ax, ay, bx, by, aw, ah, bw, bh;

	status_t           nx_st;
	logic [SLOT_W-1:0] nx_rcv;
	logic [SLOT_W-1:0] nx_oth;
	logic              nx_last;

	assign item.ready = cmd.idle;
	assign in_fire    = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	assign result.valid         = out_valid_q;
	assign result.status        = out_st_q;
	assign result.receiver_slot = out_rcv_q;
	assign result.other_slot    = out_oth_q;
	assign result.last          = out_last_q;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int j = SLOTS - 1; j >= 0; j--) begin
			if (!used_q[j]) begin
				free_found = 1'b1;
				free_idx   = IW'(j);
			end
		end
	end

	assign erase_ok = ({1'b0, slot_q} < (SLOT_W + 1)'(SLOTS)) && used_q[slot_q[IW-1:0]];
	assign row_ok   = ({1'b0, box_q.kind} < (KIND_W + 1)'(KINDS));

	// strict overlap on sign-extended coordinates, no overflow possible
	assign ax = {{2{box_a_s1.x[COORD_W-1]}}, box_a_s1.x};
	assign ay = {{2{box_a_s1.y[COORD_W-1]}}, box_a_s1.y};
	assign bx = {{2{box_b_s1.x[COORD_W-1]}}, box_b_s1.x};
	assign by = {{2{box_b_s1.y[COORD_W-1]}}, box_b_s1.y};
	assign aw = {3'b000, box_a_s1.w};
	assign ah = {3'b000, box_a_s1.h};
	assign bw = {3'b000, box_b_s1.w};
	assign bh = {3'b000, box_b_s1.h};
	assign ovl = (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);

	assign kin_a = ({1'b0, box_a_s1.kind} < (KIND_W + 1)'(KINDS));
	assign kin_b = ({1'b0, box_b_s1.kind} < (KIND_W + 1)'(KINDS));

	assign stat.in_valid  = item.valid;
	assign stat.op        = op_q;
	assign stat.out_free  = out_free;
	assign stat.pair_used = used_q[cmd.slot_a[IW-1:0]] && used_q[cmd.slot_b[IW-1:0]];
	assign stat.hit_a     = ovl_s2 && listen_a_s2 && kin_a_s2 && kin_b_s2 && mask_a_s2[kind_b_s2];
	assign stat.hit_b     = ovl_s2 && listen_b_s2 && kin_a_s2 && kin_b_s2 && mask_b_s2[kind_a_s2];

	always_comb begin
		nx_st   = ST_OK;
		nx_rcv  = '0;
		nx_oth  = '0;
		nx_last = 1'b1;
		case (cmd.sel)
			EM_ADD: begin
				nx_st  = free_found ? ST_OK : ST_FULL;
				nx_rcv = free_found ? SLOT_W'(free_idx) : '0;
			end
			EM_ERASE: begin
				nx_st  = erase_ok ? ST_OK : ST_EMPTY;
				nx_rcv = erase_ok ? slot_q : '0;
			end
			EM_LOAD: nx_st = ST_OK;
			EM_HIT_A: begin
				nx_st   = ST_HIT;
				nx_rcv  = cmd.slot_a;
				nx_oth  = cmd.slot_b;
				nx_last = 1'b0;
			end
			EM_HIT_B: begin
				nx_st   = ST_HIT;
				nx_rcv  = cmd.slot_b;
				nx_oth  = cmd.slot_a;
				nx_last = 1'b0;
			end
			EM_DONE: nx_st = ST_DONE;
			default: nx_st = ST_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			mask_vld_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (cmd.sel == EM_ADD && free_found) used_q[free_idx] <= 1'b1;
				if (cmd.sel == EM_ERASE && erase_ok) used_q[slot_q[IW-1:0]] <= 1'b0;
				if (cmd.sel == EM_LOAD && row_ok) mask_vld_q[box_q.kind[KW-1:0]] <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q          <= op_t'(item.op);
			box_q.x       <= item.box_x;
			box_q.y       <= item.box_y;
			box_q.w       <= item.box_w;
			box_q.h       <= item.box_h;
			box_q.kind    <= item.kind;
			box_q.listens <= item.has_listener;
			slot_q        <= item.slot;
			mask_row_q    <= item.mask_row;
		end
		if (cmd.emit) begin
			out_st_q   <= nx_st;
			out_rcv_q  <= nx_rcv;
			out_oth_q  <= nx_oth;
			out_last_q <= nx_last;
		end
	end

	// box table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.emit && cmd.sel == EM_ADD && free_found) box_mem[free_idx] <= box_q;
		if (cmd.pair_rd) begin
			box_a_s1 <= box_mem[cmd.slot_a[IW-1:0]];
			box_b_s1 <= box_mem[cmd.slot_b[IW-1:0]];
		end
	end

	// reaction mask table; rows never loaded read as zero
	always_ff @(posedge clk) begin
		if (cmd.emit && cmd.sel == EM_LOAD && row_ok) mask_mem[box_q.kind[KW-1:0]] <= mask_row_q;
		if (cmd.mask_rd) begin
			mask_a_s2   <= mask_vld_q[box_a_s1.kind[KW-1:0]] ?
				mask_mem[box_a_s1.kind[KW-1:0]] : '0;
			mask_b_s2   <= mask_vld_q[box_b_s1.kind[KW-1:0]] ?
				mask_mem[box_b_s1.kind[KW-1:0]] : '0;
			ovl_s2      <= ovl;
			listen_a_s2 <= box_a_s1.listens;
			listen_b_s2 <= box_b_s1.listens;
			kin_a_s2    <= kin_a;
			kin_b_s2    <= kin_b;
			kind_a_s2   <= box_a_s1.kind;
			kind_b_s2   <= box_b_s1.kind;
		end
	end

endmodule
